[src/mpq_pkg.sv]
// Shared types and constants for the max priority queue.
// No dependencies; imported by mpq_cell and max_priority_queue.
package mpq_pkg;

    localparam int CAPACITY = 32;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_cmd;

    // per-cycle operation broadcast to every cell
    typedef struct packed {
        logic ins;
        logic rem;
        logic clr;
    } t_cell_ctl;

endpackage

[src/mpq_cell.sv]
// One slot of the sorted cell chain; holds one value and its valid flag.
// Depends on mpq_pkg.
module mpq_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mpq_pkg::t_cell_ctl                i_ctl,
    input  logic signed [mpq_pkg::DATA_W-1:0] i_new_value,
    input  logic signed [mpq_pkg::DATA_W-1:0] i_left_value,
    input  logic                              i_left_valid,
    input  logic                              i_left_keep,
    input  logic signed [mpq_pkg::DATA_W-1:0] i_right_value,
    input  logic                              i_right_valid,
    output logic signed [mpq_pkg::DATA_W-1:0] o_value,
    output logic                              o_valid,
    output logic                              o_keep
);
    import mpq_pkg::*;

    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] n_value;
    logic                     r_valid;
    logic                     n_valid;

    // a cell keeps its entry on insert if it is not below the new value
    assign o_keep  = r_valid && (r_value >= i_new_value);
    assign o_value = r_value;
    assign o_valid = r_valid;

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        priority if (i_ctl.clr) begin
            n_valid = 1'b0;
        end else if (i_ctl.rem) begin
            n_value = i_right_value;
            n_valid = i_right_valid;
        end else if (i_ctl.ins) begin
            if (o_keep) begin
                n_value = r_value;
            end else if (i_left_keep) begin
                n_value = i_new_value;
                n_valid = 1'b1;
            end else begin
                // chain shifts one slot toward the tail
                n_value = i_left_value;
                n_valid = i_left_valid;
            end
        end else begin
            // no command this cycle: hold
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

[src/max_priority_queue.sv]
// Top level of the max priority queue: command decode, entry count and cell chain.
// Depends on mpq_pkg and mpq_cell.
//
// Takes one command per clock cycle; busy is never raised. The result of a command
// appears with o_strobe in the cycle right after the transfer and must be taken
// then. Entries are kept sorted in a chain of CAPACITY cells, largest in the first
// cell: an insert is one broadcast compare in every cell, a remove is one shift
// toward the head, so every command finishes in the cycle it is accepted.
module max_priority_queue (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_cmd,
    input  logic signed [mpq_pkg::DATA_W-1:0] i_value,
    output logic                              o_strobe,
    output logic                              o_ok,
    output logic signed [mpq_pkg::DATA_W-1:0] o_top_value,
    output logic [mpq_pkg::CNT_W-1:0]         o_count,
    output logic                              o_empty_res
);
    import mpq_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_strobe;
    logic             r_ok;
    logic             n_ok;
    logic             w_accept;
    t_cell_ctl        w_ctl;

    logic signed [DATA_W-1:0] w_value       [CAPACITY];
    logic                     w_valid       [CAPACITY];
    logic                     w_keep        [CAPACITY];
    logic signed [DATA_W-1:0] w_left_value  [CAPACITY];
    logic                     w_left_valid  [CAPACITY];
    logic                     w_left_keep   [CAPACITY];
    logic signed [DATA_W-1:0] w_right_value [CAPACITY];
    logic                     w_right_valid [CAPACITY];

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    always_comb begin
        w_ctl   = '0;
        n_ok    = 1'b0;
        n_count = r_count;
        if (w_accept) begin
            unique case (i_cmd)
                CMD_INSERT: begin
                    if (r_count < CNT_W'(CAPACITY)) begin
                        w_ctl.ins = 1'b1;
                        n_ok      = 1'b1;
                        n_count   = r_count + CNT_W'(1);
                    end
                end
                CMD_REMOVE: begin
                    if (r_count != '0) begin
                        w_ctl.rem = 1'b1;
                        n_ok      = 1'b1;
                        n_count   = r_count - CNT_W'(1);
                    end
                end
                CMD_CLEAR: begin
                    w_ctl.clr = 1'b1;
                    n_ok      = 1'b1;
                    n_count   = '0;
                end
                default: begin
                    n_ok = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok <= n_ok;
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_strobe <= w_accept;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_left_value[g] = '0;
            assign w_left_valid[g] = 1'b0;
            assign w_left_keep[g]  = 1'b1;
        end else begin : g_body
            assign w_left_value[g] = w_value[g-1];
            assign w_left_valid[g] = w_valid[g-1];
            assign w_left_keep[g]  = w_keep[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign w_right_value[g] = '0;
            assign w_right_valid[g] = 1'b0;
        end else begin : g_inner
            assign w_right_value[g] = w_value[g+1];
            assign w_right_valid[g] = w_valid[g+1];
        end

        mpq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_new_value   (i_value),
            .i_left_value  (w_left_value[g]),
            .i_left_valid  (w_left_valid[g]),
            .i_left_keep   (w_left_keep[g]),
            .i_right_value (w_right_value[g]),
            .i_right_valid (w_right_valid[g]),
            .o_value       (w_value[g]),
            .o_valid       (w_valid[g]),
            .o_keep        (w_keep[g])
        );
    end

    assign o_strobe    = r_strobe;
    assign o_ok        = r_ok;
    assign o_count     = r_count;
    assign o_empty_res = (r_count == '0);
    assign o_top_value = w_valid[0] ? w_value[0] : '0;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_strobe)
        else $error("no result after transfer");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) == w_valid[0])
        else $error("head cell disagrees with entry count");

    a_tail_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CNT_W'(CAPACITY)) == w_valid[CAPACITY-1])
        else $error("tail cell disagrees with entry count");

    a_head_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[1] |-> (w_valid[0] && (w_value[0] >= w_value[1])))
        else $error("head cell out of order");

endmodule

[tb/sv/tb_max_priority_queue.sv]
// Testbench for max_priority_queue: directed and random command streams against a heap predictor.
// Depends on mpq_pkg and max_priority_queue; every result is checked field by field in order.
module tb_max_priority_queue;
    import mpq_pkg::*;

    localparam logic [1:0] CMD_UNUSED     = 2'd3;
    localparam int         STALL_LIMIT    = 2000;
    localparam int         DRAIN_CYCLES   = 16;

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] top;
        logic [CNT_W-1:0]         count;
        logic                     empty;
    } t_pq_result;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic [1:0]               i_cmd;
    logic signed [DATA_W-1:0] i_value;
    logic                     o_strobe;
    logic                     o_ok;
    logic signed [DATA_W-1:0] o_top_value;
    logic [CNT_W-1:0]         o_count;
    logic                     o_empty_res;

    // predictor state: binary max heap, a different layout from the block's sorted cell chain
    logic signed [DATA_W-1:0] heap_mem [CAPACITY];
    int                       heap_len;

    t_pq_result               pending_results [$];
    t_pq_result               want;
    int                       fail_cnt;
    int                       quiet_cycles;
    bit                       run_active;
    bit                       idle_on;

    max_priority_queue u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .i_value     (i_value),
        .o_strobe    (o_strobe),
        .o_ok        (o_ok),
        .o_top_value (o_top_value),
        .o_count     (o_count),
        .o_empty_res (o_empty_res)
    );

    // low first so there is no rising edge at time zero
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Applies one command to the heap and returns the result the block must report.
    function automatic t_pq_result heap_apply(input logic [1:0] cmd,
                                              input logic signed [DATA_W-1:0] val);
        t_pq_result               r;
        int                       pos;
        int                       up;
        int                       lc;
        int                       rc;
        int                       best;
        logic signed [DATA_W-1:0] tmp;
        r.ok = 1'b0;
        case (cmd)
            CMD_INSERT: if (heap_len < CAPACITY) begin
                heap_mem[heap_len] = val;
                pos = heap_len;
                heap_len++;
                // only move past a strictly smaller parent
                while (pos > 0) begin
                    up = (pos - 1) / 2;
                    if (heap_mem[pos] <= heap_mem[up])
                        break;
                    tmp           = heap_mem[pos];
                    heap_mem[pos] = heap_mem[up];
                    heap_mem[up]  = tmp;
                    pos = up;
                end
                r.ok = 1'b1;
            end
            CMD_REMOVE: if (heap_len > 0) begin
                heap_mem[0] = heap_mem[heap_len - 1];
                heap_len--;
                pos = 0;
                // left child wins on equal children
                while (pos < heap_len) begin
                    lc   = 2 * pos + 1;
                    rc   = 2 * pos + 2;
                    best = pos;
                    if (lc < heap_len && heap_mem[lc] > heap_mem[best])
                        best = lc;
                    if (rc < heap_len && heap_mem[rc] > heap_mem[best])
                        best = rc;
                    if (best == pos)
                        break;
                    tmp            = heap_mem[pos];
                    heap_mem[pos]  = heap_mem[best];
                    heap_mem[best] = tmp;
                    pos = best;
                end
                r.ok = 1'b1;
            end
            CMD_CLEAR: begin
                heap_len = 0;
                r.ok     = 1'b1;
            end
            default: ;
        endcase
        r.top   = (heap_len > 0) ? heap_mem[0] : '0;
        r.count = CNT_W'(heap_len);
        r.empty = (heap_len == 0);
        return r;
    endfunction

    // Drives one command, holds it until the transfer, then records the expected result.
    task automatic send_cmd(input logic [1:0] cmd, input logic signed [DATA_W-1:0] val);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_cmd   <= cmd;
        i_value <= val;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        pending_results.push_back(heap_apply(cmd, val));
    endtask

    // Sender pause: hold off until every expected result is back.
    task automatic wait_results_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return {1'b1, {(DATA_W-1){1'b0}}};
            1:       return {1'b0, {(DATA_W-1){1'b1}}};
            2, 3:    return DATA_W'($signed($urandom_range(0, 15)) - 8);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_empty_queue();
        send_cmd(CMD_REMOVE, 32'sd5);
        send_cmd(CMD_CLEAR, -32'sd1);
        send_cmd(CMD_UNUSED, 32'sd7);
        send_cmd(CMD_REMOVE, '0);
    endtask

    task automatic test_extremes_and_ties();
        send_cmd(CMD_INSERT, {1'b1, {(DATA_W-1){1'b0}}});
        send_cmd(CMD_INSERT, '0);
        send_cmd(CMD_INSERT, -32'sd1);
        send_cmd(CMD_INSERT, {1'b0, {(DATA_W-1){1'b1}}});
        send_cmd(CMD_INSERT, {1'b0, {(DATA_W-1){1'b1}}});
        send_cmd(CMD_INSERT, 32'sd1);
        send_cmd(CMD_UNUSED, 32'sd99);
        send_cmd(CMD_REMOVE, 32'sd12345);
        send_cmd(CMD_REMOVE, '0);
        send_cmd(CMD_REMOVE, '0);
        send_cmd(CMD_REMOVE, '0);
        send_cmd(CMD_REMOVE, '0);
        send_cmd(CMD_REMOVE, '0);
        send_cmd(CMD_REMOVE, '0);
        send_cmd(CMD_INSERT, -32'sd3);
        send_cmd(CMD_INSERT, -32'sd3);
        send_cmd(CMD_CLEAR, '0);
        send_cmd(CMD_REMOVE, '0);
    endtask

    // Fill past capacity, then drain past empty.
    task automatic test_capacity();
        for (int i = 0; i <= CAPACITY; i++)
            send_cmd(CMD_INSERT, pick_value());
        send_cmd(CMD_UNUSED, '1);
        for (int i = 0; i <= CAPACITY; i++)
            send_cmd(CMD_REMOVE, pick_value());
    endtask

    // Segments biased toward filling, draining or mixing so full and empty are hit often.
    task automatic test_random_mix(input int n_items);
        int left;
        int ins_pct;
        int r;
        left = 0;
        ins_pct = 50;
        for (int i = 0; i < n_items; i++) begin
            if (left == 0) begin
                left = $urandom_range(8, 60);
                case ($urandom_range(0, 2))
                    0:       ins_pct = 85;
                    1:       ins_pct = 15;
                    default: ins_pct = 50;
                endcase
            end
            left--;
            r = $urandom_range(0, 99);
            if (r < 2)
                send_cmd(CMD_CLEAR, pick_value());
            else if (r < 3)
                send_cmd(CMD_UNUSED, pick_value());
            else if ($urandom_range(0, 99) < ins_pct)
                send_cmd(CMD_INSERT, pick_value());
            else
                send_cmd(CMD_REMOVE, pick_value());
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: ok=%0b top=%0d count=%0d empty=%0b",
                       o_ok, o_top_value, o_count, o_empty_res);
                fail_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (o_ok !== want.ok) begin
                    $error("ok: expected %0b, got %0b", want.ok, o_ok);
                    fail_cnt++;
                end
                if (o_top_value !== want.top) begin
                    $error("top_value: expected %0d, got %0d", want.top, o_top_value);
                    fail_cnt++;
                end
                if (o_count !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, o_count);
                    fail_cnt++;
                end
                if (o_empty_res !== want.empty) begin
                    $error("empty_res: expected %0b, got %0b", want.empty, o_empty_res);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog: cycles with neither a command transfer nor a result
    always @(posedge i_clk) begin
        if (run_active) begin
            if ((start && !busy) || o_strobe)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("max_priority_queue verification failed");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_cmd        = CMD_INSERT;
        i_value      = '0;
        heap_len     = 0;
        fail_cnt     = 0;
        quiet_cycles = 0;
        run_active   = 1'b0;
        idle_on      = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n    <= 1'b1;
        run_active <= 1'b1;

        test_empty_queue();
        idle_on = 1'b1;
        test_extremes_and_ties();
        wait_results_drained();
        test_capacity();
        wait_results_drained();
        test_random_mix(1080);
        wait_results_drained();
        idle_on = 1'b0;
        test_random_mix(180);

        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("max_priority_queue verification clean");
        else
            $display("max_priority_queue verification failed");
        $finish;
    end

endmodule

[filelist.f]
src/mpq_pkg.sv
src/mpq_cell.sv
src/max_priority_queue.sv
tb/sv/tb_max_priority_queue.sv
